FILE: rtl/bgma_pkg.sv
// ----------------------------------------------------------------------------
// bgma_pkg
// Shared types, constants and scaling functions for the battery gauge
// moving-average core.
// ----------------------------------------------------------------------------
package bgma_pkg;

    localparam int unsigned WINDOW_DEF     = 8;
    localparam int unsigned SAMPLE_W       = 12;
    localparam int unsigned MV_W           = 14;
    localparam int unsigned PCT_W          = 7;
    localparam int unsigned PROD_W         = 24;
    localparam int unsigned RADIX_BITS     = 4;

    localparam int unsigned ADC_FULL_SCALE = 4095;
    localparam int unsigned MV_SPAN        = 4000;
    localparam int unsigned MV_EMPTY       = 8000;
    localparam int unsigned MV_FULL        = 12000;
    localparam int unsigned MV_CLAMP_LOW   = 7500;
    localparam int unsigned MV_CLAMP_HIGH  = 13000;
    localparam int unsigned PCT_MAX        = 100;
    localparam int unsigned PCT_RECIP      = 205;
    localparam int unsigned PCT_SHIFT      = 10;

    typedef struct packed {
        logic                filled;
        logic [SAMPLE_W-1:0] data;
    } ring_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_QUOTIENT,
        ST_OUTPUT
    } state_t;

    // floor(product / 4095): estimate by a shift, correct once
    function automatic logic [SAMPLE_W-1:0] div_full_scale(input logic [PROD_W-1:0] product);
        logic [SAMPLE_W-1:0] q0;
        logic [SAMPLE_W:0]   rem;
        q0  = product[PROD_W-1:SAMPLE_W];
        rem = {1'b0, product[SAMPLE_W-1:0]} + {1'b0, q0};
        if (rem >= (SAMPLE_W+1)'(ADC_FULL_SCALE))
        begin
            div_full_scale = q0 + SAMPLE_W'(1);
        end
        else
        begin
            div_full_scale = q0;
        end
    endfunction

    function automatic logic [MV_W-1:0] quotient_to_mv(input logic [SAMPLE_W-1:0] q);
        logic [MV_W-1:0] mv;
        mv = MV_W'(MV_EMPTY) + MV_W'(q);
        if (mv > MV_W'(MV_CLAMP_HIGH))
        begin
            mv = MV_W'(MV_CLAMP_HIGH);
        end
        if (mv < MV_W'(MV_CLAMP_LOW))
        begin
            mv = MV_W'(MV_CLAMP_LOW);
        end
        quotient_to_mv = mv;
    endfunction

    // (mv - 8000) / 40 as ((mv - 8000) >> 3) * 205 >> 10
    function automatic logic [PCT_W-1:0] mv_to_percent(input logic [MV_W-1:0] mv);
        logic [MV_W-1:0] span;
        logic [8:0]      eighths;
        logic [16:0]     scaled;
        span    = mv - MV_W'(MV_EMPTY);
        eighths = span[11:3];
        scaled  = 17'(eighths) * 17'(PCT_RECIP);
        if (mv >= MV_W'(MV_FULL))
        begin
            mv_to_percent = PCT_W'(PCT_MAX);
        end
        else if (mv <= MV_W'(MV_EMPTY))
        begin
            mv_to_percent = '0;
        end
        else
        begin
            mv_to_percent = scaled[PCT_SHIFT+PCT_W-1:PCT_SHIFT];
        end
    endfunction

endpackage

FILE: rtl/bgma_cell.sv
// ----------------------------------------------------------------------------
// bgma_cell
// One sample slot of the window chain; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module bgma_cell
    import bgma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,
    input  ring_entry_t prev,
    output ring_entry_t cur
);

    logic                filled_reg;
    logic                filled_next;
    logic [SAMPLE_W-1:0] data_reg;
    logic [SAMPLE_W-1:0] data_next;

    always_comb
    begin
        filled_next = shift ? prev.filled : filled_reg;
        data_next   = shift ? prev.data   : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign cur.filled = filled_reg;
    assign cur.data   = data_reg;

endmodule

FILE: rtl/bgma_divider.sv
// ----------------------------------------------------------------------------
// bgma_divider
// Restoring divider of the window sum by the sample count, four quotient
// bits per cycle.
// ----------------------------------------------------------------------------
module bgma_divider
    import bgma_pkg::*;
#(
    parameter int unsigned SUM_W = 15,
    parameter int unsigned CNT_W = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [CNT_W-1:0]    divisor,
    output logic                done,
    output logic [SAMPLE_W-1:0] quotient
);

    localparam int unsigned STEPS  = (SUM_W + RADIX_BITS - 1) / RADIX_BITS;
    localparam int unsigned PAD_W  = STEPS * RADIX_BITS;
    localparam int unsigned STEP_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0]  num_reg;
    logic [PAD_W-1:0]  num_next;
    logic [PAD_W-1:0]  quo_reg;
    logic [PAD_W-1:0]  quo_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  div_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W-1:0]  rem_v;
    logic [PAD_W-1:0]  num_v;
    logic [PAD_W-1:0]  quo_v;

    always_comb
    begin
        rem_v = rem_reg;
        num_v = num_reg;
        quo_v = quo_reg;
        trial = '0;
        for (int i = 0; i < RADIX_BITS; i++)
        begin
            trial = {rem_v, num_v[PAD_W-1]};
            num_v = num_v << 1;
            if (trial >= {1'b0, div_reg})
            begin
                rem_v = CNT_W'(trial - {1'b0, div_reg});
                quo_v = {quo_v[PAD_W-2:0], 1'b1};
            end
            else
            begin
                rem_v = trial[CNT_W-1:0];
                quo_v = {quo_v[PAD_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = PAD_W'(dividend);
            quo_next  = '0;
            rem_next  = '0;
            div_next  = divisor;
            step_next = STEP_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next  = num_v;
            quo_next  = quo_v;
            rem_next  = rem_v;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SAMPLE_W-1:0];

endmodule

FILE: rtl/battery_gauge_moving_average_core.sv
// ----------------------------------------------------------------------------
// battery_gauge_moving_average_core
// Moving-average battery gauge: window mean, millivolts and charge percent.
// ----------------------------------------------------------------------------
// Each sample shifts into a chain of WINDOW cells while a running sum adds it
// and drops the sample leaving the last filled cell. The sum is divided by
// the number of samples held (1..WINDOW) in an iterative divider that yields
// four quotient bits a cycle. The mean is then captured, scaled to millivolts
// and percent, and loaded into the output register through the states
// ST_MULTIPLY, ST_QUOTIENT and ST_OUTPUT. sample_stall stays high from the
// transfer until the result is loaded into the output register, so the next
// transfer can come in the cycle after the load at the earliest; the core
// takes no new sample before the last one is through. A result waiting on
// result_stall does not block the next sample transfer, but that sample holds
// in the last stage until the output register is free, and sample_stall stays
// high for every such cycle.
// ----------------------------------------------------------------------------
module battery_gauge_moving_average_core
    import bgma_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [SAMPLE_W-1:0] averaged_sample,
    output logic [MV_W-1:0]     battery_mv,
    output logic [PCT_W-1:0]    charge_percent
);

    localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int unsigned CNT_W = $clog2(WINDOW + 1);

    ring_entry_t         chain [WINDOW+1];
    state_t              state_reg;
    state_t              state_next;
    logic                accept;
    logic                load_out;
    logic                window_full;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quotient;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SAMPLE_W-1:0] avg_next;
    logic [PROD_W-1:0]   product_reg;
    logic [PROD_W-1:0]   product_next;
    logic [SAMPLE_W-1:0] scaled_reg;
    logic [SAMPLE_W-1:0] scaled_next;
    logic [MV_W-1:0]     mv_v;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic [SAMPLE_W-1:0] avg_out_reg;
    logic [SAMPLE_W-1:0] avg_out_next;
    logic [MV_W-1:0]     mv_out_reg;
    logic [MV_W-1:0]     mv_out_next;
    logic [PCT_W-1:0]    pct_out_reg;
    logic [PCT_W-1:0]    pct_out_next;

    assign chain[0].filled = 1'b1;
    assign chain[0].data   = sample;

    for (genvar k = 0; k < WINDOW; k++)
    begin : g_cell
        bgma_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .prev  (chain[k]),
            .cur   (chain[k+1])
        );
    end

    assign window_full = chain[WINDOW].filled;

    always_comb
    begin
        sum_next = sum_reg + SUM_W'(sample);
        if (window_full)
        begin
            sum_next = sum_next - SUM_W'(chain[WINDOW].data);
        end
        if (count_reg == CNT_W'(WINDOW))
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    bgma_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next        = state_reg;
        sample_stall      = 1'b1;
        load_out          = 1'b0;
        avg_next          = avg_reg;
        product_next      = product_reg;
        scaled_next       = scaled_reg;
        mv_v              = quotient_to_mv(scaled_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    avg_next   = div_quotient;
                    state_next = ST_MULTIPLY;
                end
            end
            ST_MULTIPLY:
            begin
                product_next = PROD_W'(avg_reg) * PROD_W'(MV_SPAN);
                state_next   = ST_QUOTIENT;
            end
            ST_QUOTIENT:
            begin
                scaled_next = div_full_scale(product_reg);
                state_next  = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = sample_valid && !sample_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        avg_out_next      = avg_out_reg;
        mv_out_next       = mv_out_reg;
        pct_out_next      = pct_out_reg;
        if (load_out)
        begin
            result_valid_next = 1'b1;
            avg_out_next      = avg_reg;
            mv_out_next       = mv_v;
            pct_out_next      = mv_to_percent(mv_v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sum_reg          <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg     <= avg_next;
        product_reg <= product_next;
        scaled_reg  <= scaled_next;
        avg_out_reg <= avg_out_next;
        mv_out_reg  <= mv_out_next;
        pct_out_reg <= pct_out_next;
    end

    assign result_valid    = result_valid_reg;
    assign averaged_sample = avg_out_reg;
    assign battery_mv      = mv_out_reg;
    assign charge_percent  = pct_out_reg;

endmodule
